### rtl/usts_pkg.sv
// shared types and constants for the unordered set table
// no dependencies; used by usts_ctrl and unordered_set_table
package usts_pkg;

  localparam int FUNC_W      = 2;
  localparam int ITEM_W      = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [FUNC_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic                   overflow;
    logic                   set_empty;
    logic [COUNT_OUT_W-1:0] count_after;
    logic                   was_present;
  } result_t;

endpackage

### rtl/unordered_set_table.sv
// top level of the unordered set table: stream ports, output register
// depends on usts_pkg, usts_mem and usts_ctrl
//
//   channel | ports            | tdata (low bit up)                               | tuser
//   in      | in_t*            | item_value[31:0]                                 | func[1:0]
//   out     | out_t*           | was_present, count_after[4:0], set_empty, overflow | -
//
// an item is taken only while the sequencer is idle, so a new item waits until the last one is through;
// the search reads one stored entry per cycle from the single read port of the entry store and stops
// at a hit or at the last stored entry; a remove that moves the last entry adds a move step.
// reset clears the count and control state only; the store needs no clearing.
// a waiting result sits in the output register while the next item is taken;
// the sequencer holds its finished result until that register frees up.
module unordered_set_table #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [usts_pkg::ITEM_W-1:0]        in_tdata,  // item_value
  input  logic [usts_pkg::FUNC_W-1:0]        in_tuser,  // func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [usts_pkg::OUT_DATA_W-1:0]    out_tdata  // was_present, count_after, set_empty, overflow
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data;
  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [VALUE_WIDTH-1:0] mem_rd_data;
  logic                   res_valid;
  logic                   res_ready;
  usts_pkg::result_t      res;
  usts_pkg::result_t      out_res_r;
  logic                   out_valid_r;

  usts_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_func     (in_tuser),
    .in_value    (in_tdata),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  usts_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

endmodule

### rtl/usts_mem.sv
// entry store of the unordered set table: one write port, one read port,
// registered read data; no package dependency
module usts_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/usts_ctrl.sv
// sequencer of the unordered set table: linear search, insert at the end,
// remove by moving the last entry; depends on usts_pkg, drives usts_mem
module usts_ctrl #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 4,
  parameter int CNT_W       = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [usts_pkg::FUNC_W-1:0]    in_func,
  input  logic [usts_pkg::ITEM_W-1:0]    in_value,
  output logic                           mem_wr_en,
  output logic [AW-1:0]                  mem_wr_addr,
  output logic [VALUE_WIDTH-1:0]         mem_wr_data,
  output logic                           mem_rd_en,
  output logic [AW-1:0]                  mem_rd_addr,
  input  logic [VALUE_WIDTH-1:0]         mem_rd_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output usts_pkg::result_t              res
);

  localparam int KW = (VALUE_WIDTH > usts_pkg::ITEM_W) ? VALUE_WIDTH : usts_pkg::ITEM_W;
  localparam int OW = (CNT_W > usts_pkg::COUNT_OUT_W) ? CNT_W : usts_pkg::COUNT_OUT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_MOVE,
    S_FIN
  } state_t;

  state_t                      state_r;
  logic [usts_pkg::FUNC_W-1:0] func_r;
  logic [VALUE_WIDTH-1:0]      key_r;
  logic [AW-1:0]               idx_r;
  logic [AW-1:0]               slot_r;
  logic                        present_r;
  logic                        ovf_r;
  logic [CNT_W-1:0]            count_r;

  logic [KW-1:0]          in_ext;
  logic [VALUE_WIDTH-1:0] in_key;
  logic [OW-1:0]          cnt_ext;
  logic                   in_fire;
  logic                   hit;
  logic                   last_scan;
  logic                   full;
  logic [AW-1:0]          last_idx;
  logic                   is_insert;
  logic                   is_remove;

  // value compared on its low VALUE_WIDTH bits, zero-extended if wider
  assign in_ext    = KW'(in_value);
  assign in_key    = in_ext[VALUE_WIDTH-1:0];
  assign cnt_ext   = OW'(count_r);

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign hit       = (mem_rd_data == key_r);
  assign last_scan = (CNT_W'(idx_r) == (count_r - 1'b1));
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign last_idx  = AW'(count_r - 1'b1);
  assign is_insert = (func_r == usts_pkg::OP_INSERT);
  assign is_remove = (func_r == usts_pkg::OP_REMOVE);

  assign res_valid         = (state_r == S_FIN);
  assign res.was_present   = present_r;
  assign res.count_after   = cnt_ext[usts_pkg::COUNT_OUT_W-1:0];
  assign res.set_empty     = (count_r == '0);
  assign res.overflow      = ovf_r;

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(count_r);
    mem_wr_data = key_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        mem_rd_en = in_fire;
      end
      S_SCAN: begin
        if (!hit && !last_scan) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r + 1'b1;
        end
      end
      S_ACT: begin
        if (is_insert && !present_r && !full) begin
          mem_wr_en = 1'b1;
        end
        if (is_remove && present_r && (slot_r != last_idx)) begin
          // fetch the last entry to fill the hole
          mem_rd_en   = 1'b1;
          mem_rd_addr = last_idx;
        end
      end
      S_MOVE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = slot_r;
        mem_wr_data = mem_rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      present_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            func_r    <= in_func;
            key_r     <= in_key;
            idx_r     <= '0;
            present_r <= 1'b0;
            ovf_r     <= 1'b0;
            state_r   <= (count_r == '0) ? S_ACT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            present_r <= 1'b1;
            slot_r    <= idx_r;
            state_r   <= S_ACT;
          end else if (last_scan) begin
            state_r <= S_ACT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_ACT: begin
          state_r <= S_FIN;
          if (is_insert && !present_r) begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + 1'b1;
            end
          end
          if (is_remove && present_r) begin
            if (slot_r == last_idx) begin
              count_r <= count_r - 1'b1;
            end else begin
              state_r <= S_MOVE;
            end
          end
        end
        S_MOVE: begin
          count_r <= count_r - 1'b1;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
